// ----- rtl/core/insc_pkg.sv -----
// ----------------------------------------------------------------------------
// insc_pkg
// Shared sizes, codes and types of the incremental net span cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package insc_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int MAX_NETS  = 1024;
    localparam int MAX_PINS  = 4096;
    localparam int POS_BITS  = 32;

    localparam int CELL_W = $clog2(MAX_CELLS);      // cell index
    localparam int CIDX_W = $clog2(MAX_CELLS + 1);  // cell index incl. end entry
    localparam int NET_W  = $clog2(MAX_NETS);
    localparam int NIDX_W = $clog2(MAX_NETS + 1);
    localparam int PIN_W  = $clog2(MAX_PINS);
    localparam int PCNT_W = $clog2(MAX_PINS + 1);
    localparam int OFF_W  = 32;
    localparam int SPAN_W = 48;
    localparam int CFG_W  = 11;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int REQ_W  = 10;

    // saturation bounds of a pin position, on the widened sum
    localparam logic signed [OFF_W+1:0] POS_HI = (34'sd1 <<< (POS_BITS - 1)) - 34'sd1;
    localparam logic signed [OFF_W+1:0] POS_LO = -(34'sd1 <<< (POS_BITS - 1));

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_SET  = 2'd1,
        OP_FIN  = 2'd2,
        OP_MOVE = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_CAP   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [SPAN_W-1:0] total;
        logic [ST_W-1:0]   status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/insc_if.sv -----
// ----------------------------------------------------------------------------
// insc_in_if / insc_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface insc_in_if;
    logic                              valid;
    logic                              ready;
    logic [insc_pkg::OP_W-1:0]         operation;
    logic [insc_pkg::REQ_W-1:0]        cell_req;
    logic signed [insc_pkg::OFF_W-1:0] pin_offset;
    logic                              net_end;
    logic signed [insc_pkg::OFF_W-1:0] position;

    modport source (output valid, operation, cell_req, pin_offset, net_end, position,
                    input ready);
    modport sink   (input valid, operation, cell_req, pin_offset, net_end, position,
                    output ready);
endinterface

interface insc_out_if;
    logic                        valid;
    logic                        ready;
    logic [insc_pkg::SPAN_W-1:0] total_span;
    logic [insc_pkg::ST_W-1:0]   status;

    modport source (output valid, total_span, status, input ready);
    modport sink   (input valid, total_span, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/insc_ram.sv -----
// ----------------------------------------------------------------------------
// insc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module insc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/insc_core.sv -----
// ----------------------------------------------------------------------------
// insc_core
// Sequencer over the netlist memories: pin load, placement, index build,
// span computation and incremental move update.
// ----------------------------------------------------------------------------
`default_nettype none

module insc_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [insc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    insc_in_if.sink                          i_in,
    output logic                             o_res_valid,
    output insc_pkg::t_result                o_res,
    input  wire logic                        i_res_take
);

    localparam int PB = insc_pkg::POS_BITS;
    localparam int OW = insc_pkg::OFF_W;
    localparam int CW = insc_pkg::CELL_W;
    localparam int NW = insc_pkg::NET_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DONE,
        F_CLR, F_CNT, F_CNT2, F_CNT3, F_PRE, F_PRE2,
        F_PL0, F_PL1, F_PL2, F_PL3, F_PL4, F_SP, F_SN, F_SPAN,
        B_S0, B_S1, B_PIN, B_PIN2, B_PIN3,
        M_A, M_B, M_NET, M_NET2, M_UPD
    } t_state;

    function automatic logic signed [PB-1:0] f_sat(input logic signed [OW-1:0] a,
                                                   input logic signed [OW-1:0] b);
        logic signed [OW+1:0] s;
        begin
            s = {{2{a[OW-1]}}, a} + {{2{b[OW-1]}}, b};
            if (s > insc_pkg::POS_HI) begin
                s = insc_pkg::POS_HI;
            end else if (s < insc_pkg::POS_LO) begin
                s = insc_pkg::POS_LO;
            end
            f_sat = s[PB-1:0];
        end
    endfunction

    t_state r_state, n_state;
    logic [insc_pkg::CFG_W-1:0]  r_cfg;
    logic [insc_pkg::PCNT_W-1:0] r_base, n_base, r_open, n_open;
    logic [insc_pkg::NIDX_W-1:0] r_ntot, n_ntot, r_net, n_net;
    logic [insc_pkg::SPAN_W-1:0] r_sum, n_sum;
    logic                        r_idx, n_idx, r_fin, n_fin, r_first, n_first;
    logic [insc_pkg::ST_W-1:0]   r_status, n_status;
    logic [CW-1:0]               r_cell, n_cell, r_pcell, n_pcell;
    logic [insc_pkg::CIDX_W-1:0] r_c, n_c;
    logic [insc_pkg::PCNT_W-1:0] r_p, n_p, r_end, n_end, r_nend, n_nend;
    logic [insc_pkg::PCNT_W-1:0] r_i, n_i, r_iend, n_iend, r_acc, n_acc;
    logic [NW-1:0]               r_n, n_n;
    logic signed [OW-1:0]        r_poff, n_poff;
    logic signed [PB-1:0]        r_lo, n_lo, r_hi, n_hi;
    logic [PB-1:0]               r_old, n_old;
    logic                        r_nps_z;

    // memory ports
    logic                        nps_we, pin_we, cps_we, cur_we, cnl_we, pos_we, spn_we;
    logic [insc_pkg::NIDX_W-1:0] nps_wa, nps_ra;
    logic [insc_pkg::PCNT_W-1:0] nps_wd, nps_rd, nps_q;
    logic [insc_pkg::PIN_W-1:0]  pin_wa, pin_ra, cnl_wa, cnl_ra;
    logic [CW+OW-1:0]            pin_wd, pin_rd;
    logic [NW+OW-1:0]            cnl_wd, cnl_rd;
    logic [insc_pkg::CIDX_W-1:0] cps_wa, cps_ra, cur_wa, cur_ra;
    logic [insc_pkg::PCNT_W-1:0] cps_wd, cps_rd, cur_wd, cur_rd;
    logic [CW-1:0]               pos_wa, pos_ra;
    logic [OW-1:0]               pos_wd, pos_rd;
    logic [NW-1:0]               spn_wa, spn_ra;
    logic [PB-1:0]               spn_wd, spn_rd;

    logic [insc_pkg::CIDX_W-1:0] w_limit;
    logic [insc_pkg::PCNT_W:0]   w_idx;
    logic [PB-1:0]               w_new;
    logic signed [PB-1:0]        w_v;
    logic [CW-1:0]               w_pcell;
    logic [NW-1:0]               w_cnet;

    insc_ram #(.DEPTH(insc_pkg::MAX_NETS + 1), .WIDTH(insc_pkg::PCNT_W)) u_nps (
        .i_clk, .i_we(nps_we), .i_waddr(nps_wa), .i_wdata(nps_wd),
        .i_raddr(nps_ra), .o_rdata(nps_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_PINS), .WIDTH(CW + OW)) u_pin (
        .i_clk, .i_we(pin_we), .i_waddr(pin_wa), .i_wdata(pin_wd),
        .i_raddr(pin_ra), .o_rdata(pin_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_CELLS + 1), .WIDTH(insc_pkg::PCNT_W)) u_cps (
        .i_clk, .i_we(cps_we), .i_waddr(cps_wa), .i_wdata(cps_wd),
        .i_raddr(cps_ra), .o_rdata(cps_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_CELLS + 1), .WIDTH(insc_pkg::PCNT_W)) u_cur (
        .i_clk, .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(cur_ra), .o_rdata(cur_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_PINS), .WIDTH(NW + OW)) u_cnl (
        .i_clk, .i_we(cnl_we), .i_waddr(cnl_wa), .i_wdata(cnl_wd),
        .i_raddr(cnl_ra), .o_rdata(cnl_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_CELLS), .WIDTH(OW)) u_pos (
        .i_clk, .i_we(pos_we), .i_waddr(pos_wa), .i_wdata(pos_wd),
        .i_raddr(pos_ra), .o_rdata(pos_rd));
    insc_ram #(.DEPTH(insc_pkg::MAX_NETS), .WIDTH(PB)) u_spn (
        .i_clk, .i_we(spn_we), .i_waddr(spn_wa), .i_wdata(spn_wd),
        .i_raddr(spn_ra), .o_rdata(spn_rd));

    // start of net 0 is never stored
    assign nps_q   = r_nps_z ? '0 : nps_rd;
    assign w_limit = (r_cfg > insc_pkg::CFG_W'(insc_pkg::MAX_CELLS))
                   ? insc_pkg::CFG_W'(insc_pkg::MAX_CELLS) : r_cfg;
    assign w_idx   = {1'b0, r_base} + {1'b0, r_open};
    assign w_new   = r_hi - r_lo;
    assign w_pcell = pin_rd[OW +: CW];
    assign w_cnet  = cnl_rd[OW +: NW];
    assign w_v     = f_sat(pos_rd, r_poff);

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.total  = r_sum;
    assign o_res.status = r_status;

    always_comb begin
        n_state = r_state; n_base = r_base; n_open = r_open; n_ntot = r_ntot;
        n_net = r_net; n_sum = r_sum; n_idx = r_idx; n_fin = r_fin; n_first = r_first;
        n_status = r_status; n_cell = r_cell; n_pcell = r_pcell; n_c = r_c;
        n_p = r_p; n_end = r_end; n_nend = r_nend; n_i = r_i; n_iend = r_iend;
        n_acc = r_acc; n_n = r_n; n_poff = r_poff; n_lo = r_lo; n_hi = r_hi;
        n_old = r_old;
        nps_we = 1'b0; nps_wa = '0; nps_wd = '0; nps_ra = '0;
        pin_we = 1'b0; pin_wa = '0; pin_wd = '0; pin_ra = '0;
        cps_we = 1'b0; cps_wa = '0; cps_wd = '0; cps_ra = '0;
        cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_ra = '0;
        cnl_we = 1'b0; cnl_wa = '0; cnl_wd = '0; cnl_ra = '0;
        pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
        spn_we = 1'b0; spn_wa = '0; spn_wd = '0; spn_ra = '0;

        case (r_state)
            S_CLEAR: begin
                pos_we = 1'b1;
                pos_wa = r_c[CW-1:0];
                if (r_c == insc_pkg::CIDX_W'(insc_pkg::MAX_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
                n_c = r_c + 1'b1;
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_status = insc_pkg::ST_OK;
                    n_cell   = i_in.cell_req;
                    n_state  = S_DONE;
                    if (insc_pkg::t_op'(i_in.operation) == insc_pkg::OP_FIN) begin
                        n_c     = '0;
                        n_state = F_CLR;
                    end else if ({1'b0, i_in.cell_req} >= w_limit) begin
                        n_status = insc_pkg::ST_RANGE;
                    end else begin
                        case (insc_pkg::t_op'(i_in.operation))
                            insc_pkg::OP_LOAD: begin
                                if (w_idx >= (insc_pkg::PCNT_W + 1)'(insc_pkg::MAX_PINS)) begin
                                    n_status = insc_pkg::ST_CAP;
                                end else if (i_in.net_end && r_open != '0 &&
                                    r_ntot >= insc_pkg::NIDX_W'(insc_pkg::MAX_NETS)) begin
                                    n_status = insc_pkg::ST_CAP;
                                end else begin
                                    pin_we = 1'b1;
                                    pin_wa = w_idx[insc_pkg::PIN_W-1:0];
                                    pin_wd = {i_in.cell_req, i_in.pin_offset};
                                    if (!i_in.net_end) begin
                                        n_open = r_open + 1'b1;
                                    end else if (r_open != '0) begin
                                        // close the net: record where the next one starts
                                        n_ntot = r_ntot + 1'b1;
                                        nps_we = 1'b1;
                                        nps_wa = r_ntot + 1'b1;
                                        nps_wd = w_idx[insc_pkg::PCNT_W-1:0] + 1'b1;
                                        n_base = w_idx[insc_pkg::PCNT_W-1:0] + 1'b1;
                                        n_open = '0;
                                    end
                                end
                            end
                            insc_pkg::OP_SET: begin
                                pos_we = 1'b1;
                                pos_wa = i_in.cell_req;
                                pos_wd = i_in.position;
                            end
                            default: begin
                                pos_we = 1'b1;
                                pos_wa = i_in.cell_req;
                                pos_wd = i_in.position;
                                if (r_idx) begin
                                    n_fin   = 1'b0;
                                    cps_ra  = {1'b0, i_in.cell_req};
                                    n_state = M_A;
                                end
                            end
                        endcase
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            // ---- index build: clear, count pins per cell and prefix-sum ----
            F_CLR: begin
                cps_we = 1'b1;
                cps_wa = r_c;
                n_c    = r_c + 1'b1;
                if (r_c == insc_pkg::CIDX_W'(insc_pkg::MAX_CELLS)) begin
                    n_p     = '0;
                    n_state = F_CNT;
                end
            end
            F_CNT: begin
                if (r_p >= r_base) begin
                    n_c     = '0;
                    n_acc   = '0;
                    n_state = F_PRE;
                end else begin
                    pin_ra  = r_p[insc_pkg::PIN_W-1:0];
                    n_state = F_CNT2;
                end
            end
            F_CNT2: begin
                n_pcell = w_pcell;
                cps_ra  = {1'b0, w_pcell} + 1'b1;
                n_state = F_CNT3;
            end
            F_CNT3: begin
                cps_we  = 1'b1;
                cps_wa  = {1'b0, r_pcell} + 1'b1;
                cps_wd  = cps_rd + 1'b1;
                n_p     = r_p + 1'b1;
                n_state = F_CNT;
            end
            F_PRE: begin
                cps_ra  = r_c;
                n_state = F_PRE2;
            end
            F_PRE2: begin
                n_acc  = r_acc + cps_rd;
                cps_we = 1'b1; cps_wa = r_c; cps_wd = r_acc + cps_rd;
                cur_we = 1'b1; cur_wa = r_c; cur_wd = r_acc + cps_rd;
                n_c    = r_c + 1'b1;
                n_state = (r_c == insc_pkg::CIDX_W'(insc_pkg::MAX_CELLS)) ? F_PL0 : F_PRE;
            end
            // ---- index build: scatter pins into cell slots ----
            F_PL0: begin
                n_p = '0;
                n_n = '0;
                if (r_base == '0) begin
                    n_state = F_SP;
                end else begin
                    nps_ra  = insc_pkg::NIDX_W'(1);
                    n_state = F_PL1;
                end
            end
            F_PL1: begin
                n_nend  = nps_q;
                n_state = F_PL2;
            end
            F_PL2: begin
                if (r_p >= r_base) begin
                    n_state = F_SP;
                end else if (r_p == r_nend) begin
                    n_n     = r_n + 1'b1;
                    nps_ra  = {1'b0, r_n} + insc_pkg::NIDX_W'(2);
                    n_state = F_PL1;
                end else begin
                    pin_ra  = r_p[insc_pkg::PIN_W-1:0];
                    n_state = F_PL3;
                end
            end
            F_PL3: begin
                n_pcell = w_pcell;
                n_poff  = pin_rd[OW-1:0];
                cur_ra  = {1'b0, w_pcell};
                n_state = F_PL4;
            end
            F_PL4: begin
                cur_we  = 1'b1; cur_wa = {1'b0, r_pcell}; cur_wd = cur_rd + 1'b1;
                cnl_we  = 1'b1; cnl_wa = cur_rd[insc_pkg::PIN_W-1:0]; cnl_wd = {r_n, r_poff};
                n_p     = r_p + 1'b1;
                n_state = F_PL2;
            end
            // ---- spans of all nets ----
            F_SP: begin
                n_sum   = '0;
                n_net   = '0;
                n_fin   = 1'b1;
                n_state = F_SN;
            end
            F_SN: begin
                if (r_net >= r_ntot) begin
                    n_idx   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    nps_ra  = r_net;
                    n_state = B_S0;
                end
            end
            F_SPAN: begin
                spn_we  = 1'b1; spn_wa = r_net[NW-1:0]; spn_wd = w_new;
                n_sum   = r_sum + insc_pkg::SPAN_W'(w_new);
                n_net   = r_net + 1'b1;
                n_state = F_SN;
            end
            // ---- bounds of net r_net, shared by finalize and move ----
            B_S0: begin
                n_p     = nps_q;
                n_old   = spn_rd;
                nps_ra  = r_net + 1'b1;
                n_state = B_S1;
            end
            B_S1: begin
                n_end   = nps_q;
                n_first = 1'b1;
                n_state = B_PIN;
            end
            B_PIN: begin
                if (r_p >= r_end) begin
                    n_state = r_fin ? F_SPAN : M_UPD;
                end else begin
                    pin_ra  = r_p[insc_pkg::PIN_W-1:0];
                    n_state = B_PIN2;
                end
            end
            B_PIN2: begin
                n_poff  = pin_rd[OW-1:0];
                pos_ra  = w_pcell;
                n_state = B_PIN3;
            end
            B_PIN3: begin
                n_first = 1'b0;
                if (r_first || w_v < r_lo) n_lo = w_v;
                if (r_first || w_v > r_hi) n_hi = w_v;
                n_p     = r_p + 1'b1;
                n_state = B_PIN;
            end
            // ---- move: walk the nets on the cell ----
            M_A: begin
                n_i     = cps_rd;
                cps_ra  = {1'b0, r_cell} + 1'b1;
                n_state = M_B;
            end
            M_B: begin
                n_iend  = cps_rd;
                n_state = M_NET;
            end
            M_NET: begin
                if (r_i >= r_iend) begin
                    n_state = S_DONE;
                end else begin
                    cnl_ra  = r_i[insc_pkg::PIN_W-1:0];
                    n_state = M_NET2;
                end
            end
            M_NET2: begin
                n_net = {1'b0, w_cnet};
                if ({1'b0, w_cnet} >= r_ntot) begin
                    n_i     = r_i + 1'b1;
                    n_state = M_NET;
                end else begin
                    nps_ra  = {1'b0, w_cnet};
                    spn_ra  = w_cnet;
                    n_state = B_S0;
                end
            end
            M_UPD: begin
                spn_we  = 1'b1; spn_wa = r_net[NW-1:0]; spn_wd = w_new;
                n_sum   = r_sum + insc_pkg::SPAN_W'(w_new) - insc_pkg::SPAN_W'(r_old);
                n_i     = r_i + 1'b1;
                n_state = M_NET;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cfg   <= insc_pkg::CFG_W'(insc_pkg::MAX_CELLS);
            r_base  <= '0;
            r_open  <= '0;
            r_ntot  <= '0;
            r_sum   <= '0;
            r_idx   <= 1'b0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_base <= n_base;
            r_open <= n_open;
            r_ntot <= n_ntot;
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_c    <= n_c;
        end
        r_net <= n_net; r_fin <= n_fin; r_first <= n_first; r_status <= n_status;
        r_cell <= n_cell; r_pcell <= n_pcell; r_p <= n_p; r_end <= n_end;
        r_nend <= n_nend; r_i <= n_i; r_iend <= n_iend; r_acc <= n_acc; r_n <= n_n;
        r_poff <= n_poff; r_lo <= n_lo; r_hi <= n_hi; r_old <= n_old;
        r_nps_z <= (nps_ra == '0);
    end

endmodule

`default_nettype wire

// ----- rtl/core/incremental_net_span_cost_top.sv -----
// ----------------------------------------------------------------------------
// incremental_net_span_cost_top
// One-axis net span cost with incremental update on cell moves.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | beat
//  i_in     | in  | operation, cell_req, pin_offset, net_end, position | valid & ready
//  o_out    | out | total_span, status                              | valid & ready
//  i_cfg_*  | in  | cell_count (11b)                                | i_cfg_wr_en
//
//  Load, set and out-of-range beats go straight from idle to the result; a
//  move after finalize walks each net on the cell and each pin of those nets,
//  bound by the single pin/position RAM read ports. Finalize builds the cell
//  index and then sums the span of every net.
//  After reset a pass clears every cell position; i_in.ready is low meanwhile.
//  The output register takes a result while o_out is stalled; the core waits
//  only when that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_net_span_cost_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [insc_pkg::CFG_W-1:0] i_cfg_wr_data,
    insc_in_if.sink                         i_in,
    insc_out_if.source                      o_out
);

    logic              res_valid, res_take;
    insc_pkg::t_result res;
    logic              r_ovalid;
    insc_pkg::t_result r_out;

    insc_core u_core (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .i_in,
        .o_res_valid(res_valid),
        .o_res(res),
        .i_res_take(res_take)
    );

    assign res_take = res_valid && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.total_span = r_out.total;
    assign o_out.status     = r_out.status;

endmodule

`default_nettype wire

// ----- rtl/core/insc_chk.sv -----
// ----------------------------------------------------------------------------
// insc_chk
// Port-level checks of the net span cost block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module insc_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [insc_pkg::SPAN_W-1:0] i_out_total,
    input wire logic [insc_pkg::ST_W-1:0]   i_out_status
);

    // reset starts the position clearing pass
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready) else $error("ready during clearing pass");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("back-to-back accept");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == insc_pkg::ST_OK ||
                         i_out_status == insc_pkg::ST_CAP ||
                         i_out_status == insc_pkg::ST_RANGE))
        else $error("bad status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_total))
        else $error("stalled result changed");

endmodule

bind incremental_net_span_cost_top insc_chk u_insc_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_total(o_out.total_span),
    .i_out_status(o_out.status)
);

`default_nettype wire

// ----- sim/incremental_net_span_cost_top_tb.sv -----
// ----------------------------------------------------------------------------
// incremental_net_span_cost_top_tb
// Self-checking bench for the one-axis net span cost block. Request beats run
// through a table of directed cases, then random phases at several cell_count
// settings, then a last finalize and a few moves. Every result beat is
// compared with the bench's span cost predictor or a known table value.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_net_span_cost_top_tb;
    import insc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX  = 17;
    localparam int WDOG_MAX  = 200000;
    localparam int RAND_PINS = 1400;     // cap on pins loaded by the random phases
    localparam int PHASE_LEN = 280;

    typedef struct {
        t_op                      op;
        logic [REQ_W-1:0]         cell_id;
        logic signed [OFF_W-1:0]  off;
        logic                     nend;
        logic signed [OFF_W-1:0]  pos;
    } t_req;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        t_req             req;
        bit               known;
        logic [SPAN_W-1:0] k_total;
        t_status          k_status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;

    insc_in_if  in_ch();
    insc_out_if out_ch();

    incremental_net_span_cost_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- span cost predictor ----------------
    int unsigned         cells_used;
    int unsigned         net_start [0:MAX_NETS];
    int unsigned         pin_cell  [0:MAX_PINS-1];
    longint              pin_off   [0:MAX_PINS-1];
    int unsigned         cell_start[0:MAX_CELLS];
    int unsigned         cell_net  [0:MAX_PINS-1];
    longint              cell_pos  [0:MAX_CELLS-1];
    longint              net_lo    [0:MAX_NETS-1];
    longint              net_hi    [0:MAX_NETS-1];
    int unsigned         open_pins;
    int unsigned         nets_closed;
    logic [SPAN_W-1:0]   span_total;

    t_result span_expect[$];

    function automatic longint sat_pin(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void net_extent(int unsigned n, output longint lo, output longint hi);
        longint p;
        lo = 64'sh7fffffffffffffff;
        hi = -64'sh7fffffffffffffff - 1;
        for (int unsigned k = net_start[n]; k < net_start[n+1] && k < MAX_PINS; k++) begin
            p = sat_pin(cell_pos[pin_cell[k]] + pin_off[k]);
            if (p < lo) lo = p;
            if (p > hi) hi = p;
        end
        if (lo > hi) begin
            lo = 0;
            hi = 0;
        end
    endfunction

    function automatic void rebuild_spans();
        int unsigned cur[0:MAX_CELLS];
        logic [SPAN_W-1:0] acc;
        acc = '0;
        for (int c = 0; c <= MAX_CELLS; c++) cell_start[c] = 0;
        for (int unsigned n = 0; n < nets_closed; n++)
            for (int unsigned k = net_start[n]; k < net_start[n+1]; k++)
                cell_start[pin_cell[k] + 1]++;
        for (int c = 1; c <= MAX_CELLS; c++) cell_start[c] += cell_start[c-1];
        cur = cell_start;
        for (int unsigned n = 0; n < nets_closed; n++)
            for (int unsigned k = net_start[n]; k < net_start[n+1]; k++) begin
                cell_net[cur[pin_cell[k]]] = n;
                cur[pin_cell[k]]++;
            end
        for (int unsigned n = 0; n < nets_closed; n++) begin
            net_extent(n, net_lo[n], net_hi[n]);
            acc += SPAN_W'(net_hi[n] - net_lo[n]);
        end
        span_total = acc;
    endfunction

    function automatic void move_update(int unsigned c, longint p);
        longint lo, hi;
        int unsigned n;
        cell_pos[c] = p;
        for (int unsigned k = cell_start[c]; k < cell_start[c+1]; k++) begin
            n = cell_net[k];
            if (n >= nets_closed) continue;
            net_extent(n, lo, hi);
            span_total = span_total + SPAN_W'(hi - lo) - SPAN_W'(net_hi[n] - net_lo[n]);
            net_lo[n] = lo;
            net_hi[n] = hi;
        end
    endfunction

    function automatic t_status pin_store(int unsigned c, longint o, bit e);
        int unsigned idx;
        idx = net_start[nets_closed] + open_pins;
        if (idx >= MAX_PINS) return ST_CAP;
        if (e && open_pins >= 1 && nets_closed >= MAX_NETS) return ST_CAP;
        pin_cell[idx] = c;
        pin_off[idx] = o;
        if (!e) open_pins++;
        else if (open_pins != 0) begin
            nets_closed++;
            net_start[nets_closed] = idx + 1;
            open_pins = 0;
        end
        return ST_OK;
    endfunction

    function automatic t_result span_predict(t_req r);
        t_result res;
        int unsigned lim;
        res.status = ST_OK;
        lim = (cells_used > MAX_CELLS) ? MAX_CELLS : cells_used;
        if (r.op == OP_FIN) rebuild_spans();
        else if (r.cell_id >= lim) res.status = ST_RANGE;
        else if (r.op == OP_LOAD) res.status = pin_store(r.cell_id, longint'(r.off), r.nend);
        else if (r.op == OP_SET) cell_pos[r.cell_id] = longint'(r.pos);
        else move_update(r.cell_id, longint'(r.pos));
        res.total = span_total;
        return res;
    endfunction

    // ---------------- result side ----------------
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned out_gap = 0;
    int unsigned op_seen[4] = '{0, 0, 0, 0};
    int unsigned status_seen[3] = '{0, 0, 0};
    t_result got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("timeout: no beat for %0d cycles, %0d results pending",
                         WDOG_MAX, span_expect.size());
                $display("incremental_net_span_cost_top_tb: done, errors");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.total = out_ch.total_span;
                got.status = out_ch.status;
                results_seen++;
                if (span_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: total %0d status %0d",
                                 got.total, got.status);
                end else begin
                    want = span_expect.pop_front();
                    if (got.total !== want.total || got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected total %0d status %0d, got %0d %0d",
                                     results_seen, want.total, want.status,
                                     got.total, got.status);
                    end
                end
                // now and then no stall before the next beat, else a random gap
                out_gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, IDLE_MAX);
                out_ch.ready <= (out_gap == 0);
            end else if (out_gap > 0) begin
                out_gap--;
                if (out_gap == 0) out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------- request side ----------------
    bit in_burst = 0;

    task automatic send_req(t_req r, bit known = 0,
                            logic [SPAN_W-1:0] kt = '0, t_status ks = ST_OK);
        int unsigned w;
        t_result res;
        w = in_burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (w > 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= r.op;
        in_ch.cell_req   <= r.cell_id;
        in_ch.pin_offset <= r.off;
        in_ch.net_end    <= r.nend;
        in_ch.position   <= r.pos;
        do @(posedge i_clk); while (!in_ch.ready);
        res = span_predict(r);
        if (known) begin
            res.total = kt;
            res.status = ks;
        end
        span_expect = {span_expect, res};
        op_seen[r.op]++;
        status_seen[res.status]++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (span_expect.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cell_count(logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cells_used = v;
    endtask

    function automatic logic signed [OFF_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    function automatic t_req rand_req(int unsigned lim, bit allow_load);
        t_req r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 42 && allow_load) r.op = OP_LOAD;
        else if (pick < 57) r.op = OP_SET;
        else if (pick < 97) r.op = OP_MOVE;
        else r.op = OP_FIN;
        if ($urandom_range(0, 9) == 0) r.cell_id = REQ_W'($urandom_range(0, 1023));
        else r.cell_id = REQ_W'($urandom_range(0, ((lim < 24) ? lim : 24) - 1));
        r.off  = rand_coord();
        r.pos  = rand_coord();
        r.nend = ($urandom_range(0, 99) < 35);
        return r;
    endfunction

    t_row rows[$];

    function automatic t_req mk(t_op op, int cid, logic [31:0] off, bit e, logic [31:0] pos);
        t_req r;
        r.op = op;
        r.cell_id = REQ_W'(cid);
        r.off = off;
        r.nend = e;
        r.pos = pos;
        return r;
    endfunction

    function automatic void row(t_req r, bit known = 0,
                                logic [SPAN_W-1:0] kt = '0, t_status ks = ST_OK);
        t_row t;
        t.is_cfg = 0;
        t.cfg = '0;
        t.req = r;
        t.known = known;
        t.k_total = kt;
        t.k_status = ks;
        rows = {rows, t};
    endfunction

    function automatic void cfg_row(logic [CFG_W-1:0] v);
        t_row t;
        t.is_cfg = 1;
        t.cfg = v;
        t.req = mk(OP_LOAD, 0, 0, 0, 0);
        t.known = 0;
        t.k_total = '0;
        t.k_status = ST_OK;
        rows = {rows, t};
    endfunction

    initial begin
        logic [CFG_W-1:0] phase_cfg[6];
        t_req r;
        int unsigned lim;

        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_LOAD;
        in_ch.cell_req   = '0;
        in_ch.pin_offset = '0;
        in_ch.net_end    = 1'b0;
        in_ch.position   = '0;
        out_ch.ready     = 1'b0;

        cells_used = 1024;
        for (int i = 0; i <= MAX_NETS; i++) net_start[i] = 0;
        for (int i = 0; i <= MAX_CELLS; i++) cell_start[i] = 0;
        for (int i = 0; i < MAX_CELLS; i++) cell_pos[i] = 0;
        open_pins = 0;
        nets_closed = 0;
        span_total = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        cfg_row(11'd2047);
        row(mk(OP_LOAD, 0, 32'h7fffffff, 0, 0), 1, 0, ST_OK);
        row(mk(OP_LOAD, 1023, 32'h80000000, 1, 0), 1, 0, ST_OK);
        row(mk(OP_LOAD, 5, 0, 1, 0), 1, 0, ST_OK);           // one-pin net, dropped
        row(mk(OP_SET, 0, 0, 0, 32'h7fffffff), 1, 0, ST_OK);
        row(mk(OP_SET, 1023, 0, 0, 32'h80000000), 1, 0, ST_OK);
        row(mk(OP_MOVE, 0, 0, 0, 32'h7fffffff), 1, 0, ST_OK); // no index yet
        row(mk(OP_FIN, 0, 0, 0, 0), 1, 48'hffffffff, ST_OK); // both pins saturate
        row(mk(OP_MOVE, 1023, 0, 0, 32'h7fffffff));
        row(mk(OP_LOAD, 3, -5, 0, 0));
        row(mk(OP_LOAD, 4, 9, 1, 0));
        row(mk(OP_MOVE, 3, 0, 0, 100));                      // net not indexed yet
        row(mk(OP_SET, 4, 0, 0, -20));                       // position only
        row(mk(OP_FIN, 0, 0, 0, 0));
        row(mk(OP_MOVE, 4, 0, 0, 32'h55555555));
        row(mk(OP_LOAD, 7, 1, 0, 0));                        // left open over finalize
        row(mk(OP_FIN, 0, 0, 0, 0));
        cfg_row(11'd1);
        row(mk(OP_LOAD, 1, 0, 1, 0));
        row(mk(OP_SET, 1, 0, 0, 3));
        row(mk(OP_MOVE, 1023, 0, 0, 3));
        row(mk(OP_LOAD, 0, 32'haaaaaaaa, 1, 0));
        cfg_row(11'd1024);
        row(mk(OP_MOVE, 1023, 0, 0, 0));
        row(mk(OP_SET, 7, 0, 0, -1));
        row(mk(OP_FIN, 0, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_cell_count(rows[i].cfg);
            else
                send_req(rows[i].req, rows[i].known, rows[i].k_total, rows[i].k_status);
        end

        // random phases
        phase_cfg = '{11'd1024, 11'd2, 11'($urandom_range(3, 1023)), 11'd2047,
                      11'd1, 11'($urandom_range(1025, 2047))};
        foreach (phase_cfg[ph]) begin
            write_cell_count(phase_cfg[ph]);
            lim = (cells_used > MAX_CELLS) ? MAX_CELLS : cells_used;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 60 == 0) in_burst = ($urandom_range(0, 3) == 0);
                r = rand_req(lim, net_start[nets_closed] + open_pins < RAND_PINS);
                send_req(r);
            end
            in_burst = 0;
        end

        // rebuild over everything loaded, then move cells on the result
        write_cell_count(11'd1024);
        send_req(mk(OP_FIN, 0, 0, 0, 0));
        for (int i = 0; i < 12; i++)
            send_req(mk(OP_MOVE, $urandom_range(0, 23), 0, 0, rand_coord()));

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("covered: load %0d, set %0d, finalize %0d, move %0d beats; %0d results",
                 op_seen[OP_LOAD], op_seen[OP_SET], op_seen[OP_FIN], op_seen[OP_MOVE],
                 results_seen);
        $display("status ok %0d, capacity %0d, range %0d; nets %0d, pins %0d, mismatches %0d",
                 status_seen[ST_OK], status_seen[ST_CAP], status_seen[ST_RANGE],
                 nets_closed, net_start[nets_closed] + open_pins, mismatches);
        if (mismatches == 0 && span_expect.size() == 0)
            $display("incremental_net_span_cost_top_tb: done, clean");
        else
            $display("incremental_net_span_cost_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
